### src/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// shared types and constants of the line substring matcher
// ----------------------------------------------------------------------------
package lsm_pkg;

  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] FOLD_OFFSET = 8'd32;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW      = 2'd0,
    REG_PATTERN_HIGH     = 2'd1,
    REG_PATTERN_LENGTH   = 2'd2,
    REG_CASE_INSENSITIVE = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic        line_matched;
    logic [7:0]  line_length;
    logic [31:0] hit_total;
    logic        file_done;
  } out_word_t;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [4:0]  pattern_length;
    logic        case_insensitive;
  } cfg_t;

  // classified word between front and back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_store;
    logic       end_of_file;
  } q_word_t;

endpackage

### src/lsm_regs.sv
// ----------------------------------------------------------------------------
// lsm_regs
// apb register file holding pattern, pattern length and case folding mode
// ----------------------------------------------------------------------------
module lsm_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output lsm_pkg::cfg_t cfg_o
);
  import lsm_pkg::*;

  cfg_t       cfg_q, cfg_d;
  reg_index_e idx;
  logic       wr_en;

  assign idx    = reg_index_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PATTERN_LOW:      cfg_d.pattern_low      = pwdata;
        REG_PATTERN_HIGH:     cfg_d.pattern_high     = pwdata;
        REG_PATTERN_LENGTH:   cfg_d.pattern_length   = pwdata[4:0];
        REG_CASE_INSENSITIVE: cfg_d.case_insensitive = pwdata[0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PATTERN_LOW:      prdata = cfg_q.pattern_low;
      REG_PATTERN_HIGH:     prdata = cfg_q.pattern_high;
      REG_PATTERN_LENGTH:   prdata = {59'd0, cfg_q.pattern_length};
      REG_CASE_INSENSITIVE: prdata = {63'd0, cfg_q.case_insensitive};
      default:              prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_low      <= 64'd0;
      cfg_q.pattern_high     <= 64'd0;
      cfg_q.pattern_length   <= 5'd1;
      cfg_q.case_insensitive <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/lsm_front.sv
// ----------------------------------------------------------------------------
// lsm_front
// accepts raw bytes, drops carriage returns that do not end the file and marks stored bytes
// ----------------------------------------------------------------------------
module lsm_front (
  input  logic              in_valid_i,
  input  lsm_pkg::in_word_t in_word_i,
  output logic              in_stall_o,
  input  logic              q_full_i,
  output logic              push_o,
  output lsm_pkg::q_word_t  push_word_o
);
  import lsm_pkg::*;

  logic is_lf;
  logic is_cr;

  assign is_lf = (in_word_i.data_byte == CHAR_LF);
  assign is_cr = (in_word_i.data_byte == CHAR_CR);

  assign in_stall_o = q_full_i;

  // a lone carriage return has no effect and is taken without queueing
  assign push_o = in_valid_i && !q_full_i && !(is_cr && !in_word_i.end_of_file);

  assign push_word_o.data_byte   = in_word_i.data_byte;
  assign push_word_o.is_store    = !is_lf && !is_cr;
  assign push_word_o.end_of_file = in_word_i.end_of_file;

endmodule

### src/lsm_queue.sv
// ----------------------------------------------------------------------------
// lsm_queue
// two-entry queue of classified words between front and back
// ----------------------------------------------------------------------------
module lsm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lsm_pkg::q_word_t push_word_i,
  output logic             full_o,
  output logic             valid_o,
  output lsm_pkg::q_word_t pop_word_o,
  input  logic             pop_i
);
  import lsm_pkg::*;

  q_word_t    mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_word_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

### src/lsm_back.sv
// ----------------------------------------------------------------------------
// lsm_back
// window shift, parallel pattern compare, line counters and result register
// ----------------------------------------------------------------------------
module lsm_back #(
  parameter int LINE_MAX      = 256,
  parameter int PATTERN_BYTES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsm_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  lsm_pkg::q_word_t   q_word_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output lsm_pkg::out_word_t out_word_o,
  input  logic               out_stall_i
);
  import lsm_pkg::*;

  localparam int CW = $clog2(LINE_MAX);
  localparam int LW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] CHUNK_LAST = CW'(LINE_MAX - 1);

  logic [7:0]    win_q [PATTERN_BYTES];
  logic [7:0]    win_d [PATTERN_BYTES];
  logic [CW-1:0] cnt_q, cnt_d, cnt_new;
  logic          hit_q, hit_d, hit_new;
  logic [31:0]   total_q, total_d, total_new;
  logic          out_valid_q, out_valid_d;
  out_word_t     out_q, out_d;

  logic [7:0]    pat [16];
  logic [4:0]    len;
  logic          win_eq;
  logic          line_end;
  logic          matched;
  logic [LW-1:0] cnt_ext;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ci);
    if (ci && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + FOLD_OFFSET;
    end
    return c;
  endfunction

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      pat[j]     = cfg_i.pattern_low[8*j +: 8];
      pat[j + 8] = cfg_i.pattern_high[8*j +: 8];
    end
  end

  assign len = (cfg_i.pattern_length > 5'(PATTERN_BYTES)) ? 5'(PATTERN_BYTES)
                                                          : cfg_i.pattern_length;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    win_d[0] = q_word_i.data_byte;
    for (int k = 1; k < PATTERN_BYTES; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // newest byte lines up with the last pattern byte
  always_comb begin
    logic [3:0] pidx;
    win_eq = 1'b1;
    pidx   = 4'd0;
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      pidx = 4'(len - 5'd1 - 5'(k));
      if (5'(k) < len &&
          fold(win_d[k], cfg_i.case_insensitive) != fold(pat[pidx], cfg_i.case_insensitive)) begin
        win_eq = 1'b0;
      end
    end
  end

  always_comb begin
    cnt_new  = cnt_q;
    hit_new  = hit_q;
    line_end = q_word_i.end_of_file || !q_word_i.is_store;
    if (q_word_i.is_store) begin
      cnt_new = cnt_q + 1'b1;
      if (len != 5'd0 && cnt_new >= CW'(len) && win_eq) begin
        hit_new = 1'b1;
      end
      if (cnt_new >= CHUNK_LAST) begin
        line_end = 1'b1;
      end
    end
    matched   = (len == 5'd0) || hit_new;
    total_new = (matched && total_q != 32'hFFFF_FFFF) ? total_q + 32'd1 : total_q;
    cnt_ext   = LW'(cnt_new);
  end

  always_comb begin
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    total_d     = total_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      if (line_end) begin
        cnt_d                  = '0;
        hit_d                  = 1'b0;
        total_d                = q_word_i.end_of_file ? 32'd0 : total_new;
        out_valid_d            = 1'b1;
        out_d.line_matched     = matched;
        out_d.line_length      = (cnt_ext > LW'(255)) ? 8'd255 : cnt_ext[7:0];
        out_d.hit_total        = total_new;
        out_d.file_done        = q_word_i.end_of_file;
      end else begin
        cnt_d = cnt_new;
        hit_d = hit_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_word_i.is_store) begin
      win_q <= win_d;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      total_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### src/line_substring_matcher.sv
// ----------------------------------------------------------------------------
// line_substring_matcher
// splits a byte stream into lines and flags lines holding a configured pattern
// ----------------------------------------------------------------------------
// a line result is registered as the closing word of its line is popped from the queue
// throughput: one word per cycle while the output is not stalled, all window compares run in parallel
// a two-entry queue decouples input from output; input stalls when it is full
// reset clears line counters, hit count, queue and output valid
// pattern registers reset to zero, length 1, case folding off
module line_substring_matcher #(
  parameter int LINE_MAX      = 256,
  parameter int PATTERN_BYTES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lsm_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lsm_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import lsm_pkg::*;

  cfg_t    cfg;
  logic    q_full;
  logic    push;
  q_word_t push_word;
  logic    q_valid;
  q_word_t q_word;
  logic    pop;

  lsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsm_front u_front (
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_word_o (push_word)
  );

  lsm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_word_o  (q_word),
    .pop_i       (pop)
  );

  lsm_back #(
    .LINE_MAX      (LINE_MAX),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_word_i    (q_word),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule
